### hdl/qte_pkg.sv
package qte_pkg;

   // datapath widths
   localparam int CORDIC_W = 40;   // cordic x/y, holds the grown vector magnitude
   localparam int ANG_W    = 28;   // fine angle, degrees * 65536
   localparam int ATAN_LEN = 24;   // entries in the arctangent table

   localparam logic signed [ANG_W-1:0] FINE_90 = ANG_W'(5898240);

   // pole codes on the result beat
   localparam logic [1:0] POLE_NONE  = 2'd0;
   localparam logic [1:0] POLE_SOUTH = 2'd1;
   localparam logic [1:0] POLE_NORTH = 2'd2;

   // atan(2^-i) in degrees * 65536, rounded to nearest
   function automatic logic signed [ANG_W-1:0] atan_fine(input int idx);
      case (idx)
         0:  return ANG_W'(2949120);
         1:  return ANG_W'(1740967);
         2:  return ANG_W'(919879);
         3:  return ANG_W'(466945);
         4:  return ANG_W'(234379);
         5:  return ANG_W'(117306);
         6:  return ANG_W'(58666);
         7:  return ANG_W'(29335);
         8:  return ANG_W'(14668);
         9:  return ANG_W'(7334);
         10: return ANG_W'(3667);
         11: return ANG_W'(1833);
         12: return ANG_W'(917);
         13: return ANG_W'(458);
         14: return ANG_W'(229);
         15: return ANG_W'(115);
         16: return ANG_W'(57);
         17: return ANG_W'(29);
         18: return ANG_W'(14);
         19: return ANG_W'(7);
         20: return ANG_W'(4);
         21: return ANG_W'(2);
         22: return ANG_W'(1);
         default: return '0;
      endcase
   endfunction

endpackage

### hdl/qte_if.sv
interface qte_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;
   logic signed [15:0] quat_w;

   modport source(output valid, output quat_x, output quat_y, output quat_z,
                  output quat_w, input ready);
   modport sink(input valid, input quat_x, input quat_y, input quat_z,
                input quat_w, output ready);
endinterface

interface qte_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] pitch_deg;
   logic signed [15:0] yaw_deg;
   logic signed [15:0] roll_deg;
   logic [1:0]         pole_case;

   modport source(output valid, output pitch_deg, output yaw_deg, output roll_deg,
                  output pole_case, input ready);
   modport sink(input valid, input pitch_deg, input yaw_deg, input roll_deg,
                input pole_case, output ready);
endinterface

### hdl/quaternion_to_euler_angles.sv
// Quaternion to pitch / yaw / roll. Takes one unit quaternion (x, y, z, w, signed Q1.15) per
// cycle while the skid is empty and returns pitch, yaw and roll in 1/128 degree plus a pole
// code. The pipeline accepts a new beat every cycle while the skid is empty; it is built from
// the 31-step pipelined square root in front of the asin and the CORDIC stages that follow it.
// A one-beat skid register at the output keeps the input open in the cycle a stall begins;
// while it is full, the pipeline holds. There is no state between beats.
module quaternion_to_euler_angles
   import qte_pkg::*;
#(
   parameter int CORDIC_STAGES = 16
) (
   input logic      clock,
   input logic      reset,
   qte_req_if.sink  req_bus,
   qte_rsp_if.source rsp_bus
);

   localparam int STAGES   = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
   localparam int CLAT     = STAGES + 1;   // cordic register depth, fold stage included
   localparam int SQ_STEPS = 31;           // result bits of the square root of the Q.60 radicand

   localparam logic signed [34:0] ONE_Q30    = 35'sd1073741824;
   localparam logic signed [32:0] POLE_LIMIT = 33'sd536870375;
   localparam logic signed [20:0] TURN       = 21'sd46080;
   localparam logic signed [20:0] HALF       = 21'sd23040;
   localparam logic signed [20:0] QUARTER    = 21'sd11520;

   typedef struct packed {
      logic [1:0]                 pole;
      logic signed [30:0]         s;
      logic signed [CORDIC_W-1:0] yaw_y;
      logic signed [CORDIC_W-1:0] yaw_x;
      logic signed [CORDIC_W-1:0] roll_y;
      logic signed [CORDIC_W-1:0] roll_x;
   } side_type;

   // wrap a coarse angle into (-180, 180]; input stays within two turns
   function automatic logic signed [15:0] wrap_turn(input logic signed [20:0] v);
      logic signed [20:0] r;
      r = v;
      if (r > HALF) r = r - TURN;
      if (r > HALF) r = r - TURN;
      if (r <= -HALF) r = r + TURN;
      if (r <= -HALF) r = r + TURN;
      return r[15:0];
   endfunction

   // the whole pipeline moves together; it halts only while the skid holds a beat
   logic skid_full_ff;
   logic en;
   assign en            = !skid_full_ff;
   assign req_bus.ready = en && !reset;

   // stage 1: component products, Q2.30
   logic               v1_ff;
   logic signed [31:0] zx_ff, wy_ff, wz_ff, xy_ff, yy_ff, zz_ff, wx_ff, yz_ff, xx_ff;
   logic signed [15:0] x1_ff, w1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= req_bus.valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zx_ff <= req_bus.quat_z * req_bus.quat_x;
         wy_ff <= req_bus.quat_w * req_bus.quat_y;
         wz_ff <= req_bus.quat_w * req_bus.quat_z;
         xy_ff <= req_bus.quat_x * req_bus.quat_y;
         yy_ff <= req_bus.quat_y * req_bus.quat_y;
         zz_ff <= req_bus.quat_z * req_bus.quat_z;
         wx_ff <= req_bus.quat_w * req_bus.quat_x;
         yz_ff <= req_bus.quat_y * req_bus.quat_z;
         xx_ff <= req_bus.quat_x * req_bus.quat_x;
         x1_ff <= req_bus.quat_x;
         w1_ff <= req_bus.quat_w;
      end
   end

   // stage 2: singularity test and atan2 operands
   logic               v2_ff;
   logic signed [32:0] test_ff;
   logic signed [34:0] yaw_y_ff, yaw_x_ff, roll_y_ff, roll_x_ff;
   logic signed [15:0] x2_ff, w2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         test_ff   <= 33'(zx_ff) - 33'(wy_ff);
         yaw_y_ff  <= (35'(wz_ff) + 35'(xy_ff)) <<< 1;
         yaw_x_ff  <= ONE_Q30 - ((35'(yy_ff) + 35'(zz_ff)) <<< 1);
         roll_y_ff <= 35'sd0 - ((35'(wx_ff) + 35'(yz_ff)) <<< 1);
         roll_x_ff <= ONE_Q30 - ((35'(xx_ff) + 35'(yy_ff)) <<< 1);
         x2_ff     <= x1_ff;
         w2_ff     <= w1_ff;
      end
   end

   // stage 3: pole decision, asin argument, roll operand select
   logic     v3_ff;
   side_type side3_ff;
   side_type side3_in;

   always_comb begin
      side3_in.pole = POLE_NONE;
      if (test_ff < -POLE_LIMIT) side3_in.pole = POLE_SOUTH;
      else if (test_ff > POLE_LIMIT) side3_in.pole = POLE_NORTH;
      side3_in.yaw_y = CORDIC_W'(yaw_y_ff);
      side3_in.yaw_x = CORDIC_W'(yaw_x_ff);
      if (side3_in.pole == POLE_NONE) begin
         // |2t| < 2^30 here
         side3_in.s      = $signed({test_ff[29:0], 1'b0});
         side3_in.roll_y = CORDIC_W'(roll_y_ff);
         side3_in.roll_x = CORDIC_W'(roll_x_ff);
      end else begin
         // half angle from x and w in Q.30
         side3_in.s      = '0;
         side3_in.roll_y = CORDIC_W'(x2_ff) <<< 15;
         side3_in.roll_x = CORDIC_W'(w2_ff) <<< 15;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) side3_ff <= side3_in;
   end

   // side line: index k lines up with stage 4 + k
   side_type side_ff [0:SQ_STEPS+1];
   logic     vld_ff  [0:SQ_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= SQ_STEPS + 1; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= v3_ff;
         for (int k = 1; k <= SQ_STEPS + 1; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side3_ff;
         for (int k = 1; k <= SQ_STEPS + 1; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   // stage 4: s squared; stage 5: radicand 1 - s^2 in Q.60
   logic signed [61:0] sq_ff;
   logic [61:0]        n_ff   [0:SQ_STEPS];
   logic [61:0]        res_ff [0:SQ_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff     <= side3_ff.s * side3_ff.s;
         n_ff[0]   <= (62'd1 << 60) - $unsigned(sq_ff);
         res_ff[0] <= '0;
      end
   end

   // digit-by-digit integer square root, one result bit per stage
   for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
      localparam logic [61:0] BIT = 62'd1 << (60 - 2 * j);
      logic [61:0] trial;
      assign trial = res_ff[j] + BIT;
      always_ff @(posedge clock) begin
         if (en) begin
            if (n_ff[j] >= trial) begin
               n_ff[j+1]   <= n_ff[j] - trial;
               res_ff[j+1] <= (res_ff[j] >> 1) + BIT;
            end else begin
               n_ff[j+1]   <= n_ff[j];
               res_ff[j+1] <= res_ff[j] >> 1;
            end
         end
      end
   end

   // three vectoring cordics, all fed in step with the square root's last stage
   side_type                   side_q;
   logic signed [CORDIC_W-1:0] pitch_y, pitch_x;
   logic signed [ANG_W-1:0]    pitch_ang, yaw_ang, roll_ang;

   assign side_q  = side_ff[SQ_STEPS+1];
   assign pitch_y = CORDIC_W'(side_q.s);
   assign pitch_x = CORDIC_W'(res_ff[SQ_STEPS][30:0]);

   qte_cordic #(.STAGES(STAGES)) u_pitch (
      .clock(clock), .en(en), .y_i(pitch_y), .x_i(pitch_x), .ang_o(pitch_ang)
   );

   qte_cordic #(.STAGES(STAGES)) u_yaw (
      .clock(clock), .en(en), .y_i(side_q.yaw_y), .x_i(side_q.yaw_x), .ang_o(yaw_ang)
   );

   qte_cordic #(.STAGES(STAGES)) u_roll (
      .clock(clock), .en(en), .y_i(side_q.roll_y), .x_i(side_q.roll_x), .ang_o(roll_ang)
   );

   // pole code and valid ride alongside the cordics
   logic [1:0] pd_ff [0:CLAT-1];
   logic       pv_ff [0:CLAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CLAT; k++) pv_ff[k] <= 1'b0;
      end else if (en) begin
         pv_ff[0] <= vld_ff[SQ_STEPS+1];
         for (int k = 1; k < CLAT; k++) pv_ff[k] <= pv_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pd_ff[0] <= side_q.pole;
         for (int k = 1; k < CLAT; k++) pd_ff[k] <= pd_ff[k-1];
      end
   end

   // stage a: pole roll combine, round to 1/128 degree (half up)
   logic               va_ff;
   logic [1:0]         pa_ff;
   logic signed [20:0] yaw_c_ff, roll_c_ff, pitch_c_ff;
   logic signed [29:0] yaw_l, roll2_l, mix_l, yaw_r, roll_r, pitch_r;

   always_comb begin
      yaw_l   = 30'(yaw_ang);
      roll2_l = 30'(roll_ang) <<< 1;
      case (pd_ff[CLAT-1])
         POLE_SOUTH: mix_l = 30'sd0 - yaw_l - roll2_l;
         POLE_NORTH: mix_l = yaw_l - roll2_l;
         default:    mix_l = 30'(roll_ang);
      endcase
      yaw_r   = (yaw_l + 30'sd256) >>> 9;
      roll_r  = (mix_l + 30'sd256) >>> 9;
      pitch_r = (30'(pitch_ang) + 30'sd256) >>> 9;
   end

   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else if (en) va_ff <= pv_ff[CLAT-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff      <= pd_ff[CLAT-1];
         yaw_c_ff   <= yaw_r[20:0];
         roll_c_ff  <= roll_r[20:0];
         pitch_c_ff <= pitch_r[20:0];
      end
   end

   // stage b: wrap, clamp, pole pitch
   logic               vb_ff;
   logic [1:0]         pole_b_ff;
   logic signed [14:0] pitch_b_ff;
   logic signed [15:0] yaw_b_ff, roll_b_ff;
   logic signed [20:0] pitch_b_in;

   always_comb begin
      case (pa_ff)
         POLE_SOUTH: pitch_b_in = -QUARTER;
         POLE_NORTH: pitch_b_in = QUARTER;
         default: begin
            if (pitch_c_ff > QUARTER) pitch_b_in = QUARTER;
            else if (pitch_c_ff < -QUARTER) pitch_b_in = -QUARTER;
            else pitch_b_in = pitch_c_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) vb_ff <= 1'b0;
      else if (en) vb_ff <= va_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pole_b_ff  <= pa_ff;
         pitch_b_ff <= pitch_b_in[14:0];
         yaw_b_ff   <= wrap_turn(yaw_c_ff);
         roll_b_ff  <= wrap_turn(roll_c_ff);
      end
   end

   // output skid: catches the beat that leaves the pipe as a stall begins
   logic [1:0]         pole_s_ff;
   logic signed [14:0] pitch_s_ff;
   logic signed [15:0] yaw_s_ff, roll_s_ff;

   always_ff @(posedge clock) begin
      if (reset) skid_full_ff <= 1'b0;
      else if (!skid_full_ff) skid_full_ff <= vb_ff && !rsp_bus.ready;
      else if (rsp_bus.ready) skid_full_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (!skid_full_ff) begin
         pole_s_ff  <= pole_b_ff;
         pitch_s_ff <= pitch_b_ff;
         yaw_s_ff   <= yaw_b_ff;
         roll_s_ff  <= roll_b_ff;
      end
   end

   assign rsp_bus.valid     = skid_full_ff || vb_ff;
   assign rsp_bus.pole_case = skid_full_ff ? pole_s_ff  : pole_b_ff;
   assign rsp_bus.pitch_deg = skid_full_ff ? pitch_s_ff : pitch_b_ff;
   assign rsp_bus.yaw_deg   = skid_full_ff ? yaw_s_ff   : yaw_b_ff;
   assign rsp_bus.roll_deg  = skid_full_ff ? roll_s_ff  : roll_b_ff;

   // pole beats carry the fixed pitch
   a_pole_pitch: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.pole_case != POLE_NONE |->
         (rsp_bus.pole_case == POLE_NORTH && rsp_bus.pitch_deg == 15'sd11520) ||
         (rsp_bus.pole_case == POLE_SOUTH && rsp_bus.pitch_deg == -15'sd11520))
      else $error("pole beat with wrong pitch");

   // wrapped angles never land on the open end of the range
   a_wrap: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.yaw_deg != -16'sd23040 && rsp_bus.roll_deg != -16'sd23040)
      else $error("angle wrap out of range");

   // a held skid beat stays until taken
   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff && !rsp_bus.ready |=> skid_full_ff && $stable(yaw_s_ff))
      else $error("skid beat lost");

   // pipeline frozen while the skid is occupied
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |=> $stable(yaw_b_ff) || !skid_full_ff || !$past(skid_full_ff))
      else $error("pipeline moved under a full skid");

endmodule

### hdl/qte_cordic.sv
module qte_cordic
   import qte_pkg::*;
#(
   parameter int STAGES = 16
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic signed [CORDIC_W-1:0] y_i,
   input  logic signed [CORDIC_W-1:0] x_i,
   output logic signed [ANG_W-1:0]    ang_o
);

   logic signed [CORDIC_W-1:0] x_ff [0:STAGES];
   logic signed [CORDIC_W-1:0] y_ff [0:STAGES];
   logic signed [ANG_W-1:0]    a_ff [0:STAGES];
   logic                       zero_ff [0:STAGES];

   // quadrant fold into the right half plane
   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (x_i == '0) && (y_i == '0);
         if (x_i < 0) begin
            if (y_i >= 0) begin
               x_ff[0] <= y_i;
               y_ff[0] <= -x_i;
               a_ff[0] <= FINE_90;
            end else begin
               x_ff[0] <= -y_i;
               y_ff[0] <= x_i;
               a_ff[0] <= -FINE_90;
            end
         end else begin
            x_ff[0] <= x_i;
            y_ff[0] <= y_i;
            a_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] > 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               a_ff[i+1] <= a_ff[i] + atan_fine(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               a_ff[i+1] <= a_ff[i] - atan_fine(i);
            end
         end
      end
   end

   assign ang_o = zero_ff[STAGES] ? '0 : a_ff[STAGES];

endmodule

### tb/tb_qte_if.sv
`timescale 1ns / 100ps

// channel wrappers live with the block; this file only pins the driver and monitor beat types
package tb_qte_types;
   typedef struct packed {
      logic signed [14:0] pitch;
      logic signed [15:0] yaw;
      logic signed [15:0] roll;
      logic [1:0]         pole;
   } euler_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic signed [15:0] w;
   } quat_type;
endpackage

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import qte_pkg::*;
   import tb_qte_types::*;

   localparam int STAGES  = 16;
   localparam int LATENCY = 39 + STAGES;
   localparam longint POLE_LIM = 536870375;
   localparam longint ONE_Q30  = 64'sd1073741824;
   localparam longint FINE90   = 5898240;

   logic clock;
   logic reset;
   int   fail_count;
   bit   stim_done;

   qte_req_if req_bus();
   qte_rsp_if rsp_bus();

   quaternion_to_euler_angles #(.CORDIC_STAGES(STAGES)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   // quaternions waiting to be driven, euler angles waiting to come back
   quat_type  quat_queue[$];
   euler_type angle_queue[$];

   // fine angle table, degrees * 65536
   longint atan_deg[24] = '{2949120, 1740967, 919879, 466945, 234379, 117306, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
                            14, 7, 4, 2, 1, 0};

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // floor shift, the >>> of a signed longint already floors
   function automatic longint fine_atan2(longint yy, longint xx);
      longint ang, t, dx, dy;
      ang = 0;
      if (xx == 0 && yy == 0) return 0;
      // fold the left half plane onto the right
      if (xx < 0) begin
         if (yy >= 0) begin
            t = xx; xx = yy; yy = -t; ang = FINE90;
         end else begin
            t = xx; xx = -yy; yy = t; ang = -FINE90;
         end
      end
      for (int i = 0; i < STAGES && i < 24; i++) begin
         dx = yy >>> i;
         dy = xx >>> i;
         if (yy > 0) begin
            xx += dx; yy -= dy; ang += atan_deg[i];
         end else begin
            xx -= dx; yy += dy; ang -= atan_deg[i];
         end
      end
      return ang;
   endfunction

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(res);
   endfunction

   // 1/128 degree, round half up
   function automatic longint to_coarse(longint fine);
      return (fine + 256) >>> 9;
   endfunction

   function automatic longint wrap_turn(longint v);
      longint r;
      r = v % 46080;
      if (r < 0) r += 46080;
      if (r > 23040) r -= 46080;
      return r;
   endfunction

   function automatic euler_type euler_of(quat_type q);
      longint x, y, z, w, test, yaw_y, yaw_x, yaw_f, half, s, c, pitch, roll, yaw;
      longint unsigned c2;
      euler_type e;
      x = q.x; y = q.y; z = q.z; w = q.w;
      test  = z * x - w * y;
      yaw_y = 2 * (w * z + x * y);
      yaw_x = ONE_Q30 - 2 * (y * y + z * z);
      yaw_f = fine_atan2(yaw_y, yaw_x);
      yaw   = wrap_turn(to_coarse(yaw_f));
      if (test < -POLE_LIM || test > POLE_LIM) begin
         half = fine_atan2(x * 32768, w * 32768);
         if (test < 0) begin
            e.pole = POLE_SOUTH;
            pitch  = -11520;
            roll   = wrap_turn(to_coarse(-yaw_f - 2 * half));
         end else begin
            e.pole = POLE_NORTH;
            pitch  = 11520;
            roll   = wrap_turn(to_coarse(yaw_f - 2 * half));
         end
      end else begin
         s  = 2 * test;
         c2 = (64'd1 << 60) - longint'(s * s);
         c  = int_sqrt(c2);
         e.pole = POLE_NONE;
         pitch = to_coarse(fine_atan2(s, c));
         if (pitch > 11520) pitch = 11520;
         if (pitch < -11520) pitch = -11520;
         roll = wrap_turn(to_coarse(fine_atan2(-2 * (w * x + y * z),
                                               ONE_Q30 - 2 * (x * x + y * y))));
      end
      e.pitch = pitch[14:0];
      e.yaw   = yaw[15:0];
      e.roll  = roll[15:0];
      return e;
   endfunction

   // gap length: mostly zero or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic quat_type rand_quat();
      quat_type q;
      int       mode;
      mode = $urandom_range(0, 9);
      q.x = 16'($urandom);
      q.y = 16'($urandom);
      q.z = 16'($urandom);
      q.w = 16'($urandom);
      if (mode < 5) begin
         // random components halved, so each stays within +-0.5
         q.x = $signed(16'($urandom)) >>> 1;
         q.y = $signed(16'($urandom)) >>> 1;
         q.z = $signed(16'($urandom)) >>> 1;
         q.w = $signed(16'($urandom)) >>> 1;
      end else if (mode < 7) begin
         // near a pole: z*x - w*y about +-0.5
         q.x = 16'(16'sd23170 + $signed(16'($urandom_range(0, 200))) - 100);
         q.z = q.x;
         q.y = 16'($signed(16'($urandom_range(0, 400))) - 200);
         q.w = q.y;
         if ($urandom_range(0, 1)) q.z = -q.z;
         if ($urandom_range(0, 1)) q.w = -q.w;
      end else if (mode == 7) begin
         q.x = $urandom_range(0, 1) ? -16'sd32768 : 16'sd32767;
         q.w = 16'($signed(16'($urandom_range(0, 3))) - 2);
      end
      return q;
   endfunction

   // ---------------------------------------------------------------- driver
   int drv_gap;
   bit req_taken;

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         drv_gap       <= 0;
      end else if (req_bus.valid && !req_taken) begin
         // hold the offered beat
      end else if (drv_gap > 0) begin
         req_bus.valid <= 1'b0;
         drv_gap       <= drv_gap - 1;
      end else if (quat_queue.size() > 0) begin
         quat_type q;
         q = quat_queue.pop_front();
         req_bus.valid  <= 1'b1;
         req_bus.quat_x <= q.x;
         req_bus.quat_y <= q.y;
         req_bus.quat_z <= q.z;
         req_bus.quat_w <= q.w;
         drv_gap        <= pick_gap();
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // predict on each accepted beat
   int accepted;

   always @(posedge clock) begin
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         quat_type q;
         q.x = req_bus.quat_x;
         q.y = req_bus.quat_y;
         q.z = req_bus.quat_z;
         q.w = req_bus.quat_w;
         angle_queue.push_back(euler_of(q));
         accepted <= accepted + 1;
      end
   end

   // --------------------------------------------------------------- monitor
   int hold_cnt;
   int long_hold;

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         euler_type got, exp_e;
         got.pitch = rsp_bus.pitch_deg;
         got.yaw   = rsp_bus.yaw_deg;
         got.roll  = rsp_bus.roll_deg;
         got.pole  = rsp_bus.pole_case;
         if (angle_queue.size() == 0) begin
            $error("result beat with nothing expected");
            fail_count++;
         end else begin
            exp_e = angle_queue.pop_front();
            if (got.pitch !== exp_e.pitch) begin
               $error("pitch_deg expected %0d got %0d", exp_e.pitch, got.pitch);
               fail_count++;
            end
            if (got.yaw !== exp_e.yaw) begin
               $error("yaw_deg expected %0d got %0d", exp_e.yaw, got.yaw);
               fail_count++;
            end
            if (got.roll !== exp_e.roll) begin
               $error("roll_deg expected %0d got %0d", exp_e.roll, got.roll);
               fail_count++;
            end
            if (got.pole !== exp_e.pole) begin
               $error("pole_case expected %0d got %0d", exp_e.pole, got.pole);
               fail_count++;
            end
         end
      end
   end

   // receiver stalls; one long hold-off once the pipeline has traffic
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_cnt      <= 0;
      end else if (hold_cnt > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_cnt      <= hold_cnt - 1;
      end else if (!long_hold && accepted > 300) begin
         long_hold     <= 1;
         rsp_bus.ready <= 1'b0;
         hold_cnt      <= 4 * LATENCY;
      end else if ($urandom_range(0, 99) < 25 && accepted > 40 && accepted < 900) begin
         rsp_bus.ready <= 1'b0;
         hold_cnt      <= pick_gap();
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------- stimulus
   initial begin
      quat_type q;
      fail_count = 0;
      accepted   = 0;
      long_hold  = 0;
      stim_done  = 0;
      req_bus.valid  = 1'b0;
      req_bus.quat_x = '0;
      req_bus.quat_y = '0;
      req_bus.quat_z = '0;
      req_bus.quat_w = '0;
      rsp_bus.ready  = 1'b0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: identity, zero, extremes, both poles, atan2 on the negative axis
      quat_queue.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd32767});
      quat_queue.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
      quat_queue.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
      quat_queue.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
      quat_queue.push_back('{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767});
      quat_queue.push_back('{16'sd23170, 16'sd0, 16'sd23170, 16'sd0});
      quat_queue.push_back('{16'sd23170, 16'sd0, -16'sd23170, 16'sd0});
      quat_queue.push_back('{16'sd0, 16'sd23170, 16'sd0, 16'sd23170});
      quat_queue.push_back('{16'sd0, -16'sd23170, 16'sd0, 16'sd23170});
      quat_queue.push_back('{16'sd0, 16'sd0, 16'sd0, -16'sd32768});
      quat_queue.push_back('{16'sd32767, 16'sd0, 16'sd0, 16'sd0});
      quat_queue.push_back('{16'sd0, 16'sd32767, 16'sd0, 16'sd0});
      quat_queue.push_back('{16'sd0, 16'sd0, 16'sd32767, 16'sd0});
      quat_queue.push_back('{16'sd0, 16'sd0, -16'sd32768, 16'sd0});
      quat_queue.push_back('{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384});
      quat_queue.push_back('{16'sd23170, 16'sd1, 16'sd23170, -16'sd1});
      quat_queue.push_back('{-16'sd23170, 16'sd0, 16'sd23170, 16'sd0});
      quat_queue.push_back('{16'sd1, -16'sd1, 16'sd1, -16'sd1});

      for (int i = 0; i < 1250; i++) begin
         q = rand_quat();
         quat_queue.push_back(q);
      end

      wait (quat_queue.size() == 0 && !req_bus.valid);
      wait (angle_queue.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0 && angle_queue.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

### filelist.f
hdl/qte_pkg.sv
hdl/qte_if.sv
hdl/qte_cordic.sv
hdl/quaternion_to_euler_angles.sv
tb/tb_qte_if.sv
tb/tb.sv
